// File: hw/rtl/fuzzy_signature_scanner_assert.svh
// Assertion macros shared by the scanner's checker.
// No dependencies; included by bare file name.
`ifndef FUZZY_SIGNATURE_SCANNER_ASSERT_SVH
`define FUZZY_SIGNATURE_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define FSS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define FSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/fss_pkg.sv
// Shared types and constants of the fuzzy signature scanner.
// No dependencies; compiled first.
package fss_pkg;

   localparam int BYTE_BITS         = 8;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 64;
   localparam int MATCH_BITS        = 6;
   localparam int OFFSET_OUT_BITS   = 32;
   localparam int REG_PATTERN_BYTES = 31;
   localparam int PATTERN_REG_BITS  = 4 * CSR_DATA_BITS;
   localparam logic [MATCH_BITS-1:0] MIN_MATCHES_RESET = 6'd31;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LO    = 3'd0,
      CSR_PATTERN_MID   = 3'd1,
      CSR_PATTERN_UPPER = 3'd2,
      CSR_PATTERN_TOP   = 3'd3,
      CSR_FINAL_BYTE    = 3'd4,
      CSR_MIN_MATCHES   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] pattern_top;
      logic [CSR_DATA_BITS-1:0] pattern_upper;
      logic [CSR_DATA_BITS-1:0] pattern_mid;
      logic [CSR_DATA_BITS-1:0] pattern_lo;
      logic [BYTE_BITS-1:0]     final_byte;
      logic [MATCH_BITS-1:0]    min_matches;
   } cfg_type;

endpackage

// File: hw/rtl/fss_ifs.sv
// Valid/ready channel interfaces for the scanner's byte input and result output.
// Depends on fss_pkg.
interface fss_req_if
   import fss_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;
   logic                 end_of_region;

   modport source (output valid, output data_byte, output end_of_region, input ready);
   modport sink   (input valid, input data_byte, input end_of_region, output ready);
endinterface

interface fss_rsp_if
   import fss_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [OFFSET_OUT_BITS-1:0] hit_offset;

   modport source (output valid, output found, output hit_offset, input ready);
   modport sink   (input valid, input found, input hit_offset, output ready);
endinterface

// File: hw/rtl/fuzzy_signature_scanner.sv
// An accepted item lands in the window stage; its report, if it has one, is loaded into
// the result register when that stage advances, which waits while that register is full.
// Throughput: one byte per cycle; input stalls only while the result register
// holds an untaken result. Reset (synchronous): clears the pipeline, rearms the scan and
// restores register defaults.
// Depends on fss_pkg, fss_ifs and fss_match.
module fuzzy_signature_scanner
   import fss_pkg::*;
#(
   parameter int PATTERN_LEN = 32,
   parameter int OFFSET_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   fss_req_if.sink                   req_bus,
   fss_rsp_if.source                 rsp_bus,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int WIDE_BITS = (OFFSET_BITS > OFFSET_OUT_BITS) ? OFFSET_BITS : OFFSET_OUT_BITS;

   cfg_type cfg_ff;

   logic [PATTERN_LEN-1:0][BYTE_BITS-1:0] win_ff, win_in;
   logic [OFFSET_BITS-1:0]                seen_ff, seen_in, seen_base;
   logic                                  stage_valid_ff, stage_valid_in;
   logic                                  region_end_ff, region_end_in;
   logic                                  hit_ff, hit_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  rsp_found_ff, rsp_found_in;
   logic [OFFSET_OUT_BITS-1:0]            rsp_offset_ff, rsp_offset_in;

   logic                   accept, out_free, advance, full, window_hit, hit_now, emit;
   logic [OFFSET_BITS-1:0] offset_diff;
   logic [WIDE_BITS-1:0]   offset_wide;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_lo    <= '0;
         cfg_ff.pattern_mid   <= '0;
         cfg_ff.pattern_upper <= '0;
         cfg_ff.pattern_top   <= '0;
         cfg_ff.final_byte    <= '0;
         cfg_ff.min_matches   <= MIN_MATCHES_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LO:    cfg_ff.pattern_lo    <= csr_wdata;
            CSR_PATTERN_MID:   cfg_ff.pattern_mid   <= csr_wdata;
            CSR_PATTERN_UPPER: cfg_ff.pattern_upper <= csr_wdata;
            CSR_PATTERN_TOP:   cfg_ff.pattern_top   <= csr_wdata;
            CSR_FINAL_BYTE:    cfg_ff.final_byte    <= csr_wdata[BYTE_BITS-1:0];
            CSR_MIN_MATCHES:   cfg_ff.min_matches   <= csr_wdata[MATCH_BITS-1:0];
            default: ;
         endcase
      end
   end

   fss_match #(
      .PATTERN_LEN(PATTERN_LEN)
   ) u_match (
      .window(win_ff),
      .cfg   (cfg_ff),
      .hit   (window_hit)
   );

   assign out_free        = !rsp_valid_ff || rsp_bus.ready;
   assign advance         = stage_valid_ff && out_free;
   assign req_bus.ready   = !stage_valid_ff || out_free;
   assign accept          = req_bus.valid && req_bus.ready;

   always_comb begin
      // Restart the byte count after a region's last item.
      seen_base      = region_end_ff ? '0 : seen_ff;
      seen_in        = (&seen_base) ? seen_base : seen_base + 1'b1;
      win_in         = {req_bus.data_byte, win_ff[PATTERN_LEN-1:1]};
      region_end_in  = accept ? req_bus.end_of_region : region_end_ff;
      stage_valid_in = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);

      full        = (seen_ff >= OFFSET_BITS'(PATTERN_LEN));
      hit_now     = full && window_hit && !hit_ff;
      emit        = advance && !hit_ff && (hit_now || region_end_ff);
      hit_in      = advance ? (!region_end_ff && (hit_ff || hit_now)) : hit_ff;
      offset_diff = seen_ff - OFFSET_BITS'(PATTERN_LEN);
      offset_wide = WIDE_BITS'(offset_diff);

      rsp_valid_in  = emit ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
      rsp_found_in  = emit ? hit_now : rsp_found_ff;
      rsp_offset_in = emit ? (hit_now ? offset_wide[OFFSET_OUT_BITS-1:0] : '0) : rsp_offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         region_end_ff  <= 1'b1;
         hit_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         region_end_ff  <= region_end_in;
         hit_ff         <= hit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff  <= win_in;
         seen_ff <= seen_in;
      end
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.found      = rsp_found_ff;
   assign rsp_bus.hit_offset = rsp_offset_ff;

endmodule

// File: hw/rtl/fss_match.sv
// Window comparator: counts bytes equal to the pattern and checks the threshold.
// Depends on fss_pkg.
module fss_match
   import fss_pkg::*;
#(
   parameter int PATTERN_LEN = 32
) (
   input  logic [PATTERN_LEN-1:0][BYTE_BITS-1:0] window,
   input  cfg_type                               cfg,
   output logic                                  hit
);

   localparam int CNT_BITS = $clog2(PATTERN_LEN + 1);
   localparam int CMP_BITS = (CNT_BITS > MATCH_BITS) ? CNT_BITS : MATCH_BITS;

   logic [PATTERN_REG_BITS-1:0]           pattern_flat;
   logic [PATTERN_LEN-1:0][BYTE_BITS-1:0] pattern;
   logic [PATTERN_LEN-1:0]                equal;
   logic [CNT_BITS-1:0]                   count;

   assign pattern_flat = {cfg.pattern_top, cfg.pattern_upper, cfg.pattern_mid, cfg.pattern_lo};

   // Last position uses its own register; positions past the stored bytes compare with zero.
   for (genvar j = 0; j < PATTERN_LEN; j++) begin : g_pos
      if (j == PATTERN_LEN - 1) begin : g_final
         assign pattern[j] = cfg.final_byte;
      end else if (j < REG_PATTERN_BYTES) begin : g_reg
         assign pattern[j] = pattern_flat[BYTE_BITS*j +: BYTE_BITS];
      end else begin : g_zero
         assign pattern[j] = '0;
      end
      assign equal[j] = (window[j] == pattern[j]);
   end

   assign count = CNT_BITS'($countones(equal));
   assign hit   = (CMP_BITS'(count) >= CMP_BITS'(cfg.min_matches));

endmodule

// File: hw/rtl/fss_checker.sv
// Port-level checker for the fuzzy signature scanner, bound to the top level.
// Depends on fss_pkg and fuzzy_signature_scanner_assert.svh.
`include "fuzzy_signature_scanner_assert.svh"

module fss_checker
   import fss_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_found,
   input logic [OFFSET_OUT_BITS-1:0] rsp_hit_offset
);

   logic                     rsp_stall;
   logic [OFFSET_OUT_BITS:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_found, rsp_hit_offset};

   // A stalled result keeps its value.
   `FSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // A region that ends without a hit reports offset zero.
   `FSS_ASSERT_IMPLY(a_miss_offset, clock, reset, rsp_valid && !rsp_found, rsp_hit_offset == '0)

   // Input backpressure only comes from an untaken result.
   `FSS_ASSERT_IMPLY(a_ready_cause, clock, reset, !req_ready, rsp_stall)

   // Reset empties the result register.
   `FSS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind fuzzy_signature_scanner fss_checker u_fss_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_found     (rsp_bus.found),
   .rsp_hit_offset(rsp_bus.hit_offset)
);

// File: bench/fuzzy_signature_scanner_tb.sv
// Self-checking bench for fuzzy_signature_scanner: byte regions in, hit/miss reports out.
// Depends on fss_pkg, fss_ifs and the scanner RTL; predicts every report in-line.
module fuzzy_signature_scanner_tb;
   import fss_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAT_LEN      = 32;
   localparam int OFF_BITS     = 32;
   localparam int PHASES       = 7;
   localparam int PHASE_BYTES  = 45;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic                       found;
      logic [OFFSET_OUT_BITS-1:0] offset;
   } scan_report_type;

   typedef enum logic {ROW_RUN, ROW_SET_MIN} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   value;
      int unsigned  count;
      bit           eor;
      bit           typed;
      bit           has_report;
      logic         found;
      logic [31:0]  offset;
   } dir_row_type;

   logic clock;
   logic reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   fss_req_if req_bus ();
   fss_rsp_if rsp_bus ();

   fuzzy_signature_scanner #(
      .PATTERN_LEN (PAT_LEN),
      .OFFSET_BITS (OFF_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register image and scan state as the block should hold them
   logic [63:0]         pat_words [4] = '{default: '0};
   logic [7:0]          final_ref     = '0;
   logic [5:0]          min_ref       = MIN_MATCHES_RESET;
   logic [7:0]          scan_window [PAT_LEN];
   logic [OFF_BITS-1:0] scan_seen;
   bit                  scan_hit;

   scan_report_type expected_reports [$];

   int unsigned mismatches    = 0;
   int unsigned bytes_sent    = 0;
   int unsigned live_bytes    = 0;
   int unsigned hits          = 0;
   int unsigned misses        = 0;
   int unsigned settings_used = 0;
   int unsigned hold_requests = 0;
   int unsigned cycle_count   = 0;
   bit          steady_stretch = 1'b0;

   // Typed rows use the reset pattern (all zero, final byte zero) or a run of one byte.
   dir_row_type directed_rows [20] = '{
      '{ROW_RUN,     8'h00,  1, 1, 1, 1, 1'b0, 32'd0},
      '{ROW_RUN,     8'hFF,  1, 1, 1, 1, 1'b0, 32'd0},
      '{ROW_RUN,     8'h00, 32, 1, 1, 1, 1'b1, 32'd0},
      '{ROW_RUN,     8'h80,  1, 0, 1, 0, 1'b0, 32'd0},
      '{ROW_RUN,     8'h00, 31, 0, 1, 1, 1'b1, 32'd0},
      '{ROW_RUN,     8'hAB,  3, 0, 1, 0, 1'b0, 32'd0},
      '{ROW_RUN,     8'h01,  1, 1, 1, 0, 1'b0, 32'd0},
      '{ROW_RUN,     8'hFF,  5, 0, 1, 0, 1'b0, 32'd0},
      '{ROW_RUN,     8'h00, 31, 0, 1, 1, 1'b1, 32'd4},
      '{ROW_RUN,     8'h7E,  1, 1, 1, 0, 1'b0, 32'd0},
      '{ROW_RUN,     8'h55, 20, 1, 1, 1, 1'b0, 32'd0},
      '{ROW_SET_MIN, 8'd0,   0, 0, 0, 0, 1'b0, 32'd0},
      '{ROW_RUN,     8'h5A, 32, 1, 1, 1, 1'b1, 32'd0},
      '{ROW_RUN,     8'hC3, 33, 1, 0, 0, 1'b0, 32'd0},
      '{ROW_SET_MIN, 8'd33,  0, 0, 0, 0, 1'b0, 32'd0},
      '{ROW_RUN,     8'h00, 32, 1, 1, 1, 1'b0, 32'd0},
      '{ROW_SET_MIN, 8'd32,  0, 0, 0, 0, 1'b0, 32'd0},
      '{ROW_RUN,     8'h00, 32, 1, 1, 1, 1'b1, 32'd0},
      '{ROW_RUN,     8'h00, 31, 0, 1, 0, 1'b0, 32'd0},
      '{ROW_RUN,     8'h01,  1, 1, 1, 1, 1'b0, 32'd0}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] pattern_byte(input int unsigned pos);
      if (pos >= REG_PATTERN_BYTES)
         return 8'h00;
      return pat_words[pos / 8][8 * (pos % 8) +: 8];
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Half the filler borrows pattern bytes so windows partly line up
   function automatic logic [7:0] filler_byte();
      if ($urandom_range(1))
         return 8'($urandom);
      return pattern_byte($urandom_range(0, REG_PATTERN_BYTES - 1));
   endfunction

   function automatic void rearm_scan();
      foreach (scan_window[i])
         scan_window[i] = '0;
      scan_seen = '0;
      scan_hit  = 1'b0;
   endfunction

   function automatic void advance_scan(input logic [7:0] b, input logic eor,
                                        output bit emits, output scan_report_type rep,
                                        output bit ignored);
      int unsigned equal_count;
      emits   = 1'b0;
      rep     = '0;
      ignored = scan_hit;
      if (scan_hit) begin
         if (eor)
            rearm_scan();
         return;
      end
      for (int i = 0; i < PAT_LEN - 1; i++)
         scan_window[i] = scan_window[i + 1];
      scan_window[PAT_LEN - 1] = b;
      if (scan_seen != '1)
         scan_seen++;
      if (scan_seen >= PAT_LEN) begin
         equal_count = 0;
         for (int i = 0; i < PAT_LEN - 1; i++)
            if (scan_window[i] == pattern_byte(i))
               equal_count++;
         if (scan_window[PAT_LEN - 1] == final_ref)
            equal_count++;
         if (equal_count >= min_ref) begin
            emits      = 1'b1;
            rep.found  = 1'b1;
            rep.offset = OFFSET_OUT_BITS'(scan_seen - PAT_LEN);
            scan_hit   = 1'b1;
            if (eor)
               rearm_scan();
            return;
         end
      end
      if (eor) begin
         emits = 1'b1;
         rearm_scan();
      end
   endfunction

   task automatic offer_byte(input logic [7:0] b, input logic eor, input bit use_model);
      bit              emits;
      bit              ignored;
      scan_report_type rep;
      while (!steady_stretch && $urandom_range(99) < 21) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= b;
      req_bus.end_of_region <= eor;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      advance_scan(b, eor, emits, rep, ignored);
      bytes_sent++;
      if (!ignored)
         live_bytes++;
      if (emits && use_model)
         expected_reports.push_back(rep);
   endtask

   // Drop valid, wait out every report, then let the pipeline empty
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      unique case (idx)
         CSR_PATTERN_LO:    pat_words[0] = v;
         CSR_PATTERN_MID:   pat_words[1] = v;
         CSR_PATTERN_UPPER: pat_words[2] = v;
         CSR_PATTERN_TOP:   pat_words[3] = v;
         CSR_FINAL_BYTE:    final_ref = v[7:0];
         CSR_MIN_MATCHES:   min_ref = v[5:0];
         default: ;
      endcase
   endtask

   task automatic program_scanner(input logic [63:0] lo, input logic [63:0] mid,
                                  input logic [63:0] up, input logic [63:0] top,
                                  input logic [7:0] fb, input logic [5:0] mm);
      write_csr(CSR_PATTERN_LO, lo);
      write_csr(CSR_PATTERN_MID, mid);
      write_csr(CSR_PATTERN_UPPER, up);
      write_csr(CSR_PATTERN_TOP, top);
      write_csr(CSR_FINAL_BYTE, 64'(fb));
      write_csr(CSR_MIN_MATCHES, 64'(mm));
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Short region, region with a planted and lightly damaged signature, or plain noise
   task automatic scan_region();
      logic [7:0]  region [$];
      logic [7:0]  sig [PAT_LEN];
      int unsigned pick;
      int unsigned flips;
      int unsigned spot;
      pick = $urandom_range(99);
      if (pick < 30) begin
         repeat ($urandom_range(1, PAT_LEN - 1)) region.push_back(filler_byte());
      end else if (pick < 85) begin
         repeat ($urandom_range(0, 24)) region.push_back(filler_byte());
         for (int i = 0; i < PAT_LEN; i++)
            sig[i] = (i == PAT_LEN - 1) ? final_ref : pattern_byte(i);
         flips = $urandom_range(0, 6);
         repeat (flips) begin
            spot = $urandom_range(0, PAT_LEN - 1);
            sig[spot] ^= 8'($urandom_range(1, 255));
         end
         for (int i = 0; i < PAT_LEN; i++)
            region.push_back(sig[i]);
         repeat ($urandom_range(0, 8)) region.push_back(filler_byte());
      end else begin
         repeat ($urandom_range(PAT_LEN, 2 * PAT_LEN)) region.push_back(filler_byte());
      end
      foreach (region[i])
         offer_byte(region[i], i == region.size() - 1, 1'b1);
   endtask

   // Result side: random stalls, one long hold on request, none during the steady stretch
   initial begin : rsp_side
      int unsigned hold_left;
      int unsigned served;
      hold_left = 0;
      served    = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (served != hold_requests) begin
            served    = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady_stretch || ($urandom_range(99) >= 21);
         end
      end
   end

   always @(posedge clock) begin : report_check
      scan_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected report: found=%0b hit_offset=%0d",
                   rsp_bus.found, rsp_bus.hit_offset);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_bus.found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_bus.found);
               mismatches++;
            end
            if (rsp_bus.hit_offset !== want.offset) begin
               $error("hit_offset: expected %0d, got %0d", want.offset,
                      rsp_bus.hit_offset);
               mismatches++;
            end
            if (want.found)
               hits++;
            else
               misses++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d reports outstanding", cycle_count,
                expected_reports.size());
         $display("fuzzy_signature_scanner_tb: errors");
         $finish;
      end
   end

   initial begin : stimulus
      dir_row_type row;
      bit          last;
      int unsigned phase_start;
      int unsigned regions;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.data_byte     <= '0;
      req_bus.end_of_region <= 1'b0;
      csr_wr_en             <= 1'b0;
      csr_index             <= CSR_PATTERN_LO;
      csr_wdata             <= '0;
      rearm_scan();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_SET_MIN) begin
            settle();
            write_csr(CSR_MIN_MATCHES, 64'(row.value));
            csr_wr_en <= 1'b0;
            settings_used++;
         end else begin
            for (int n = 0; n < row.count; n++) begin
               last = (n == row.count - 1);
               offer_byte(row.value, row.eor && last, !row.typed);
               if (row.typed && last && row.has_report)
                  expected_reports.push_back(
                     scan_report_type'{found: row.found, offset: row.offset});
            end
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         unique case (ph)
            0: program_scanner(random_word(), random_word(), random_word(), random_word(),
                               8'($urandom), 6'd28);
            1: program_scanner('1, '1, '1, '1, 8'hFF, 6'd32);
            2: program_scanner(random_word(), random_word(), random_word(), random_word(),
                               8'($urandom), 6'd0);
            3: program_scanner(random_word(), random_word(), random_word(), random_word(),
                               8'($urandom), 6'd63);
            4: program_scanner(random_word(), random_word(), random_word(), random_word(),
                               8'($urandom), 6'($urandom_range(16, 32)));
            5: program_scanner('0, '0, '0, '0, 8'h00, 6'd30);
            default: program_scanner(random_word(), random_word(), random_word(),
                                     random_word(), 8'($urandom), 6'd31);
         endcase
         steady_stretch = (ph == PHASES - 1);
         if (ph == 2) begin
            // Back up the result path with one-byte regions while the receiver holds off
            hold_requests++;
            repeat (40) offer_byte(8'($urandom), 1'b1, 1'b1);
         end
         phase_start = live_bytes;
         regions     = 0;
         while (live_bytes - phase_start < PHASE_BYTES || regions < 2) begin
            scan_region();
            regions++;
         end
      end

      settle();
      steady_stretch = 1'b0;
      repeat (8) @(posedge clock);
      $display("Scanned %0d bytes (%0d not skipped after a hit) under %0d register settings;",
               bytes_sent, live_bytes, settings_used);
      $display("checked %0d hit and %0d miss reports.", hits, misses);
      if (mismatches == 0)
         $display("fuzzy_signature_scanner_tb: clean");
      else
         $display("fuzzy_signature_scanner_tb: errors");
      $finish;
   end

endmodule
